// ===== sv/sthr_pkg.sv =====
// shared types and constants for the shot timer hit recorder
package sthr_pkg;

   // field widths
   localparam int TYPE_W      = 3;
   localparam int TIME_W      = 32;
   localparam int STATION_W   = 8;
   localparam int PHASE_W     = 3;
   localparam int VHITS_W     = 6;
   localparam int MAXSHOT_W   = 6;
   localparam int PAR_W       = 20;
   localparam int GUARD_W     = 16;

   // port widths
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 152;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 20;

   // ring size default
   localparam int HIT_SLOTS_DEFAULT = 32;

   // slot memory word: station above time
   localparam int SLOT_W = STATION_W + TIME_W;

   // event kinds
   localparam logic [TYPE_W-1:0] REQ_START_NEW  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_MARK_START = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_HIT        = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_TICK       = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_FORCE_STOP = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_ABORT      = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_CLEAR_DONE = 3'd6;

   // session phases
   localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ARMED   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_RUNNING = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CLEAR   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_STOPPED = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_SHOTS     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAR_TIME      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GUARD         = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RESERVE_FIRST = 2'd3;

   // result word, last member in the lowest bits
   typedef struct packed {
      logic [3:0]           pad;
      logic [TIME_W-1:0]    total_ms;
      logic                 auto_stopped;
      logic                 par_expired;
      logic [VHITS_W-1:0]   valid_hits;
      logic [TIME_W-1:0]    split_ms;
      logic [TIME_W-1:0]    elapsed_ms;
      logic [STATION_W-1:0] hit_station;
      logic [TIME_W-1:0]    shot_number;
      logic                 hit_accepted;
      logic [PHASE_W-1:0]   session_state;
   } rsp_word_type;

endpackage

// ===== sv/sthr_ram.sv =====
// generic single-port-write ram with registered read
module sthr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/shot_timer_hit_recorder.sv =====
// shot timer session recorder top level: event control, slot ring and result register
// an accepted word is latched, then run in EXEC, which loads the result and raises rsp_tvalid
// one word at a time, set by the slot ram: the previous-slot read is issued
//   at accept and its data is used, with the slot write, in the EXEC state
// a waiting result word blocks the next word's EXEC step only, not its accept
// reset (synchronous, active high) clears registers, session state and slot valid bits
module shot_timer_hit_recorder
#(
   parameter int HIT_SLOTS = sthr_pkg::HIT_SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // event words
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // now_ms, station, hit_ms
   input  logic [sthr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type
   input  logic [sthr_pkg::TYPE_W-1:0]      req_tuser,
   // result words
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // session_state, hit_accepted, shot_number, hit_station, elapsed_ms,
   // split_ms, valid_hits, par_expired, auto_stopped, total_ms, zero pad
   output logic [sthr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // register writes
   input  logic                             csr_we,
   input  logic [sthr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [sthr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import sthr_pkg::*;

   // slot address and count widths
   localparam int AW = $clog2(HIT_SLOTS);
   localparam int CW = $clog2(HIT_SLOTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctl_state_type;

   // configuration registers
   logic [MAXSHOT_W-1:0] max_shots_ff;
   logic [PAR_W-1:0]     par_time_ff;
   logic [GUARD_W-1:0]   guard_ff;
   logic                 reserve_first_ff;

   // control
   ctl_state_type state_ff, state_in;
   logic          accept;
   logic          exec_go;
   logic          rsp_tvalid_ff, rsp_tvalid_in;

   // latched event word
   logic [TYPE_W-1:0]    req_type_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [STATION_W-1:0] station_ff;
   logic [TIME_W-1:0]    htime_ff;

   // session state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               started_ff, started_in;
   logic [TIME_W-1:0]  shot_total_ff, shot_total_in;
   logic [CW-1:0]      lin_pos_ff, lin_pos_in;
   logic [TIME_W-1:0]  start_time_ff, start_time_in;
   logic [TIME_W-1:0]  guard_open_ff, guard_open_in;
   logic               par_armed_ff, par_armed_in;
   logic [TIME_W-1:0]  par_deadline_ff, par_deadline_in;
   logic [CW-1:0]      slot_count_ff, slot_count_in;
   // shot_total modulo the full ring and modulo the ring without slot zero
   logic [AW-1:0]      res_full_ff, res_full_in;
   logic [AW-1:0]      res_short_ff, res_short_in;
   logic [HIT_SLOTS-1:0] slot_valid_ff, slot_valid_in;

   // memory side
   logic [AW-1:0]     slot_cur;
   logic [AW-1:0]     rd_addr;
   logic              rd_valid_ff;
   logic [SLOT_W-1:0] rd_data;
   logic              mem_we;
   logic [TIME_W-1:0] prev_time;

   // hit datapath
   logic              lim_on;
   logic [TIME_W-1:0] limit;
   logic [TIME_W-1:0] guard_diff;
   logic [TIME_W-1:0] par_diff;
   logic              hit_ok;
   logic [TIME_W-1:0] new_total;
   logic [CW-1:0]     ring;
   logic [CW-1:0]     vhits_next;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] split;
   logic              stop;

   rsp_word_type rsp_word_ff, rsp_word_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_shots_ff     <= '0;
         par_time_ff      <= '0;
         guard_ff         <= '0;
         reserve_first_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAX_SHOTS:     max_shots_ff     <= csr_wdata[MAXSHOT_W-1:0];
            CSR_PAR_TIME:      par_time_ff      <= csr_wdata[PAR_W-1:0];
            CSR_GUARD:         guard_ff         <= csr_wdata[GUARD_W-1:0];
            CSR_RESERVE_FIRST: reserve_first_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // handshake: one word in flight, the EXEC step waits for a free result register
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (exec_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (exec_go) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // ring slot of the next hit: offset plus shot_total modulo ring size
   assign slot_cur = reserve_first_ff ? (res_short_ff + AW'(1)) : res_full_ff;

   // read the preceding slot for a hit, the last valid slot for clear done
   always_comb begin
      rd_addr = '0;
      if (req_tuser == REQ_HIT) begin
         if (slot_cur != '0) rd_addr = slot_cur - AW'(1);
      end else begin
         if (slot_count_ff != '0) rd_addr = AW'(slot_count_ff - CW'(1));
      end
   end

   sthr_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (HIT_SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (slot_cur),
      .wdata ({station_ff, htime_ff}),
      .re    (accept),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   // slots cleared by start new read as zero
   assign prev_time = rd_valid_ff ? rd_data[TIME_W-1:0] : '0;

   // hit acceptance and figures
   assign lim_on     = (max_shots_ff != '0);
   assign limit      = (TIME_W'(max_shots_ff) > TIME_W'(HIT_SLOTS)) ?
                       TIME_W'(HIT_SLOTS) : TIME_W'(max_shots_ff);
   assign guard_diff = now_ff - guard_open_ff;
   assign par_diff   = now_ff - par_deadline_ff;
   assign hit_ok     = (phase_ff == PH_RUNNING) && !guard_diff[TIME_W-1] && started_ff &&
                       !(lim_on && (lin_pos_ff >= CW'(HIT_SLOTS)));
   assign new_total  = shot_total_ff + TIME_W'(1);
   assign ring       = reserve_first_ff ? CW'(HIT_SLOTS - 1) : CW'(HIT_SLOTS);
   assign vhits_next = (new_total < TIME_W'(ring)) ? CW'(new_total) : ring;
   assign elapsed    = (start_time_ff == '0) ? '0 : (htime_ff - start_time_ff);
   assign split      = (slot_cur == '0) ? elapsed : (htime_ff - prev_time);
   assign stop       = lim_on && (new_total >= limit);

   // event execution
   always_comb begin
      phase_in        = phase_ff;
      started_in      = started_ff;
      shot_total_in   = shot_total_ff;
      lin_pos_in      = lin_pos_ff;
      start_time_in   = start_time_ff;
      guard_open_in   = guard_open_ff;
      par_armed_in    = par_armed_ff;
      par_deadline_in = par_deadline_ff;
      slot_count_in   = slot_count_ff;
      res_full_in     = res_full_ff;
      res_short_in    = res_short_ff;
      slot_valid_in   = slot_valid_ff;
      mem_we          = 1'b0;
      rsp_word_in     = '0;
      if (exec_go) begin
         case (req_type_ff)
            REQ_START_NEW: begin
               slot_valid_in = '0;
               started_in    = 1'b1;
               shot_total_in = '0;
               lin_pos_in    = '0;
               start_time_in = '0;
               slot_count_in = '0;
               guard_open_in = '0;
               par_armed_in  = 1'b0;
               res_full_in   = '0;
               res_short_in  = '0;
               phase_in      = PH_ARMED;
            end
            REQ_MARK_START: begin
               if (started_ff) begin
                  start_time_in = now_ff;
                  guard_open_in = now_ff + TIME_W'(guard_ff);
                  phase_in      = PH_RUNNING;
                  if (par_time_ff != '0) begin
                     par_armed_in    = 1'b1;
                     par_deadline_in = now_ff + TIME_W'(par_time_ff);
                  end
               end
            end
            REQ_HIT: begin
               if (hit_ok) begin
                  mem_we                  = 1'b1;
                  slot_valid_in[slot_cur] = 1'b1;
                  shot_total_in           = new_total;
                  slot_count_in           = vhits_next;
                  // residues restart when the shot count wraps
                  if (new_total == '0) begin
                     res_full_in  = '0;
                     res_short_in = '0;
                  end else begin
                     res_full_in  = (res_full_ff == AW'(HIT_SLOTS - 1)) ?
                                    '0 : res_full_ff + AW'(1);
                     res_short_in = (res_short_ff == AW'(HIT_SLOTS - 2)) ?
                                    '0 : res_short_ff + AW'(1);
                  end
                  if (lin_pos_ff < CW'(HIT_SLOTS)) lin_pos_in = CW'(slot_cur) + CW'(1);
                  if (stop) begin
                     phase_in     = PH_CLEAR;
                     par_armed_in = 1'b0;
                  end
                  rsp_word_in.hit_accepted = 1'b1;
                  rsp_word_in.shot_number  = new_total;
                  rsp_word_in.hit_station  = station_ff;
                  rsp_word_in.elapsed_ms   = elapsed;
                  rsp_word_in.split_ms     = split;
                  rsp_word_in.valid_hits   = VHITS_W'(vhits_next);
                  rsp_word_in.auto_stopped = stop;
               end
            end
            REQ_TICK: begin
               if (par_armed_ff && (par_time_ff != '0)) begin
                  if (phase_ff != PH_RUNNING) begin
                     par_armed_in = 1'b0;
                  end else if (!par_diff[TIME_W-1]) begin
                     par_armed_in            = 1'b0;
                     rsp_word_in.par_expired = 1'b1;
                  end
               end
            end
            REQ_FORCE_STOP: begin
               par_armed_in = 1'b0;
               phase_in     = PH_CLEAR;
            end
            REQ_ABORT: begin
               par_armed_in = 1'b0;
               phase_in     = PH_IDLE;
            end
            REQ_CLEAR_DONE: begin
               if (phase_ff == PH_CLEAR) begin
                  lin_pos_in = '0;
                  phase_in   = PH_STOPPED;
                  if ((lin_pos_ff != '0) && started_ff && (slot_count_ff != '0) &&
                      (start_time_ff != '0)) begin
                     rsp_word_in.total_ms = prev_time - start_time_ff;
                  end
               end
            end
            default: ;
         endcase
         rsp_word_in.session_state = phase_in;
      end
   end

   // control and session registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_tvalid_ff   <= 1'b0;
         phase_ff        <= PH_IDLE;
         started_ff      <= 1'b0;
         shot_total_ff   <= '0;
         lin_pos_ff      <= '0;
         start_time_ff   <= '0;
         guard_open_ff   <= '0;
         par_armed_ff    <= 1'b0;
         par_deadline_ff <= '0;
         slot_count_ff   <= '0;
         res_full_ff     <= '0;
         res_short_ff    <= '0;
         slot_valid_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
         phase_ff        <= phase_in;
         started_ff      <= started_in;
         shot_total_ff   <= shot_total_in;
         lin_pos_ff      <= lin_pos_in;
         start_time_ff   <= start_time_in;
         guard_open_ff   <= guard_open_in;
         par_armed_ff    <= par_armed_in;
         par_deadline_ff <= par_deadline_in;
         slot_count_ff   <= slot_count_in;
         res_full_ff     <= res_full_in;
         res_short_ff    <= res_short_in;
         slot_valid_ff   <= slot_valid_in;
      end
   end

   // event word capture and result register
   always_ff @(posedge clock) begin
      if (accept) begin
         req_type_ff <= req_tuser;
         now_ff      <= req_tdata[TIME_W-1:0];
         station_ff  <= req_tdata[TIME_W+STATION_W-1:TIME_W];
         htime_ff    <= req_tdata[REQ_TDATA_W-1:TIME_W+STATION_W];
         rd_valid_ff <= slot_valid_ff[rd_addr];
      end
      if (exec_go) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_word_ff;

   // an accepted word holds off the next accept while it is in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second word accepted while one is in flight");

   // linear position never passes the ring size
   a_lin_pos_range: assert property (@(posedge clock) disable iff (reset)
      lin_pos_ff <= CW'(HIT_SLOTS))
      else $error("linear position beyond ring size");

   // valid slot count never passes the ring size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      slot_count_ff <= CW'(HIT_SLOTS))
      else $error("slot count beyond ring size");

   // a slot is written only for a recorded hit and then shows up as valid
   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> slot_valid_ff[$past(slot_cur)])
      else $error("written slot not marked valid");

   // a result word never reports a hit and a par expiry together
   a_exclusive_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_word_ff.hit_accepted && rsp_word_ff.par_expired))
      else $error("hit and par expiry in one word");

endmodule

// ===== dv/testbench.sv =====
// stimulus, prediction and checking for the shot timer hit recorder
`timescale 1ns / 100ps

module testbench;
   import sthr_pkg::*;

   localparam int SLOT_COUNT  = 32;
   localparam int RESET_CYC   = 9;
   localparam int SETTLE_CYC  = 6;       // quiet cycles before a register write
   localparam int END_CYC     = 12;      // tail after the last result word
   localparam int IDLE_LIMIT  = 4000;    // cycles without any handshake
   localparam int WORD_TARGET = 660;

   // what the driver takes from its queue
   typedef enum logic [1:0] {
      ITEM_WORD,
      ITEM_CSR,
      ITEM_DRAIN
   } item_kind_type;

   typedef struct packed {
      item_kind_type           what;
      logic [TYPE_W-1:0]       evt;
      logic [TIME_W-1:0]       now_ms;
      logic [STATION_W-1:0]    stn;
      logic [TIME_W-1:0]       hit_ms;
      logic [CSR_ADDR_W-1:0]   addr;
      logic [CSR_DATA_W-1:0]   wdata;
      logic                    calm;
   } stim_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [TYPE_W-1:0]      req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   stim_item_type stim_q[$];
   rsp_word_type expected_rsp[$];
   int unsigned  fail_count = 0;
   int unsigned  rsp_checked = 0;
   int unsigned  words_queued = 0;
   int unsigned  gap_left = 0;
   int unsigned  stall_left = 0;
   int unsigned  settle_cnt = 0;
   int unsigned  idle_cycles = 0;
   logic         calm_mode = 1'b0;    // no idling on either side while set
   logic         gen_calm = 1'b0;

   // register copies seen by the generator, to shape the sessions
   int unsigned  gen_guard = 0;
   int unsigned  gen_par = 0;

   // predictor: register copies
   logic [MAXSHOT_W-1:0] cfg_max_shots = '0;
   logic [PAR_W-1:0]     cfg_par = '0;
   logic [GUARD_W-1:0]   cfg_guard = '0;
   logic                 cfg_reserve = 1'b0;

   // predictor: session state
   logic [PHASE_W-1:0]   sess_phase = PH_IDLE;
   logic                 sess_open = 1'b0;
   logic [TIME_W-1:0]    shot_count = '0;
   int unsigned          ring_reach = 0;     // one past the highest slot written
   logic [TIME_W-1:0]    start_ms = '0;
   logic [TIME_W-1:0]    guard_end_ms = '0;
   logic                 par_live = 1'b0;
   logic [TIME_W-1:0]    par_due_ms = '0;
   int unsigned          valid_slots = 0;
   logic [STATION_W-1:0] slot_stn[SLOT_COUNT];
   logic [TIME_W-1:0]    slot_ms[SLOT_COUNT];

   shot_timer_hit_recorder #(
      .HIT_SLOTS(SLOT_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // true once now has caught up with mark, across the 2^32 wrap
   function automatic logic at_or_after(input logic [TIME_W-1:0] now_ms,
                                        input logic [TIME_W-1:0] mark_ms);
      logic [TIME_W-1:0] diff;
      diff = now_ms - mark_ms;
      return ~diff[TIME_W-1];
   endfunction

   task automatic apply_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      case (addr)
         CSR_MAX_SHOTS:     cfg_max_shots = data[MAXSHOT_W-1:0];
         CSR_PAR_TIME:      cfg_par = data[PAR_W-1:0];
         CSR_GUARD:         cfg_guard = data[GUARD_W-1:0];
         CSR_RESERVE_FIRST: cfg_reserve = data[0];
         default: ;
      endcase
   endtask

   // advances the session by one event word and returns its result word
   function automatic rsp_word_type session_step(input logic [TYPE_W-1:0]    evt,
                                                 input logic [TIME_W-1:0]    now_ms,
                                                 input logic [STATION_W-1:0] stn,
                                                 input logic [TIME_W-1:0]    hit_ms);
      rsp_word_type      r;
      logic [MAXSHOT_W-1:0] limit;
      int unsigned       first, ring, slot, last;
      logic [TIME_W-1:0] el;
      logic              taken, stop;
      r = '0;
      // shot limits above the ring size act as the ring size
      limit = (cfg_max_shots > MAXSHOT_W'(SLOT_COUNT)) ? MAXSHOT_W'(SLOT_COUNT)
                                                       : cfg_max_shots;
      case (evt)
         REQ_START_NEW: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               slot_stn[i] = '0;
               slot_ms[i] = '0;
            end
            sess_open = 1'b1;
            shot_count = '0;
            ring_reach = 0;
            start_ms = '0;
            valid_slots = 0;
            guard_end_ms = '0;
            par_live = 1'b0;
            sess_phase = PH_ARMED;
         end
         REQ_MARK_START: begin
            // ignored until a session exists, otherwise (re)starts the clock
            if (sess_open) begin
               start_ms = now_ms;
               guard_end_ms = now_ms + {16'd0, cfg_guard};
               sess_phase = PH_RUNNING;
               if (cfg_par != '0) begin
                  par_live = 1'b1;
                  par_due_ms = now_ms + {12'd0, cfg_par};
               end
            end
         end
         REQ_HIT: begin
            taken = sess_phase == PH_RUNNING && at_or_after(now_ms, guard_end_ms) &&
                    sess_open && !(limit != '0 && ring_reach >= SLOT_COUNT);
            if (taken) begin
               first = cfg_reserve ? 1 : 0;
               ring = SLOT_COUNT - first;
               shot_count = shot_count + 32'd1;
               slot = first + int'((shot_count - 32'd1) % ring);
               slot_stn[slot] = stn;
               slot_ms[slot] = hit_ms;
               valid_slots = (shot_count < ring) ? int'(shot_count) : ring;
               if (ring_reach < SLOT_COUNT) ring_reach = slot + 1;
               el = (start_ms == '0) ? '0 : slot_ms[slot] - start_ms;
               stop = limit != '0 && shot_count >= {26'd0, limit};
               if (stop) begin
                  sess_phase = PH_CLEAR;
                  par_live = 1'b0;
               end
               r.hit_accepted = 1'b1;
               r.shot_number = shot_count;
               r.hit_station = stn;
               r.elapsed_ms = el;
               // a locked slot zero still serves as the predecessor of slot one
               r.split_ms = (slot == 0) ? el : slot_ms[slot] - slot_ms[slot - 1];
               r.valid_hits = 6'(valid_slots);
               r.auto_stopped = stop;
            end
         end
         REQ_TICK: begin
            if (par_live && cfg_par != '0) begin
               if (sess_phase != PH_RUNNING) begin
                  par_live = 1'b0;
               end else if (at_or_after(now_ms, par_due_ms)) begin
                  par_live = 1'b0;
                  r.par_expired = 1'b1;
               end
            end
         end
         REQ_FORCE_STOP: begin
            par_live = 1'b0;
            sess_phase = PH_CLEAR;
         end
         REQ_ABORT: begin
            par_live = 1'b0;
            sess_phase = PH_IDLE;
         end
         REQ_CLEAR_DONE: begin
            if (sess_phase == PH_CLEAR) begin
               last = ring_reach;
               ring_reach = 0;
               sess_phase = PH_STOPPED;
               if (last > 0 && sess_open && valid_slots > 0 && start_ms != '0)
                  r.total_ms = slot_ms[valid_slots - 1] - start_ms;
            end
         end
         default: ;    // unknown kind leaves everything as it was
      endcase
      r.session_state = sess_phase;
      return r;
   endfunction

   // ---------------------------------------------------------------- idling

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap(input logic calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : driver
      stim_item_type head;
      logic       nxt_valid, nxt_we;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_we <= 1'b0;
         gap_left = 0;
         settle_cnt = 0;
      end else begin
         nxt_valid = req_tvalid;
         nxt_we = 1'b0;
         // register write lands at this edge
         if (csr_we) apply_csr(csr_addr, csr_wdata);
         // event word accepted: predict its result now
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(session_step(req_tuser, req_tdata[31:0],
                                                req_tdata[39:32], req_tdata[71:40]));
            nxt_valid = 1'b0;
            gap_left = pick_gap(calm_mode);
         end
         if (!nxt_valid && stim_q.size() > 0) begin
            head = stim_q[0];
            case (head.what)
               ITEM_WORD: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     req_tdata <= {head.hit_ms, head.stn, head.now_ms};
                     req_tuser <= head.evt;
                     calm_mode = head.calm;
                     nxt_valid = 1'b1;
                     void'(stim_q.pop_front());
                  end
               end
               ITEM_CSR: begin
                  csr_addr <= head.addr;
                  csr_wdata <= head.wdata;
                  nxt_we = 1'b1;
                  void'(stim_q.pop_front());
               end
               default: begin
                  // hold off until every result is back, then a few quiet cycles
                  if (expected_rsp.size() == 0) begin
                     if (settle_cnt >= SETTLE_CYC) begin
                        settle_cnt = 0;
                        void'(stim_q.pop_front());
                     end else begin
                        settle_cnt++;
                     end
                  end
               end
            endcase
         end
         req_tvalid <= nxt_valid;
         csr_we <= nxt_we;
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [TIME_W-1:0] got,
                                input logic [TIME_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                   rsp_checked, name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      rsp_word_type got, want;
      int unsigned  pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("result word %0h with nothing pending", rsp_tdata));
            end else begin
               want = expected_rsp.pop_front();
               compare_field("session_state", 32'(got.session_state), 32'(want.session_state));
               compare_field("hit_accepted", 32'(got.hit_accepted), 32'(want.hit_accepted));
               compare_field("shot_number", got.shot_number, want.shot_number);
               compare_field("hit_station", 32'(got.hit_station), 32'(want.hit_station));
               compare_field("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
               compare_field("split_ms", got.split_ms, want.split_ms);
               compare_field("valid_hits", 32'(got.valid_hits), 32'(want.valid_hits));
               compare_field("par_expired", 32'(got.par_expired), 32'(want.par_expired));
               compare_field("auto_stopped", 32'(got.auto_stopped), 32'(want.auto_stopped));
               compare_field("total_ms", got.total_ms, want.total_ms);
            end
            rsp_checked++;
         end
         // receiver stalls
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            pause = pick_gap(calm_mode);
            stall_left = (pause > 0) ? pause - 1 : 0;
            rsp_tready <= (pause == 0);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_word(input logic [TYPE_W-1:0] evt, input logic [TIME_W-1:0] now_ms,
                            input logic [STATION_W-1:0] stn, input logic [TIME_W-1:0] hit_ms);
      stim_item_type it;
      it = '0;
      it.what = ITEM_WORD;
      it.evt = evt;
      it.now_ms = now_ms;
      it.stn = stn;
      it.hit_ms = hit_ms;
      it.calm = gen_calm;
      stim_q.push_back(it);
      words_queued++;
   endtask

   task automatic push_drain();
      stim_item_type it;
      it = '0;
      it.what = ITEM_DRAIN;
      stim_q.push_back(it);
   endtask

   task automatic push_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      stim_item_type it;
      it = '0;
      it.what = ITEM_CSR;
      it.addr = addr;
      it.wdata = data;
      stim_q.push_back(it);
   endtask

   // all four registers, written only once the block has gone quiet
   task automatic program_regs(input int unsigned max_shots, input int unsigned par_ms,
                               input int unsigned guard_ms, input int unsigned reserve);
      push_drain();
      push_csr(CSR_MAX_SHOTS, 20'(max_shots));
      push_csr(CSR_PAR_TIME, 20'(par_ms));
      push_csr(CSR_GUARD, 20'(guard_ms));
      push_csr(CSR_RESERVE_FIRST, 20'(reserve));
      gen_par = par_ms;
      gen_guard = guard_ms;
   endtask

   task automatic push_noise();
      push_word(3'($urandom_range(0, 7)), $urandom, 8'($urandom), $urandom);
   endtask

   // one session: mostly a start, a mark, a run of hits with ticks and noise, then at times a stop
   task automatic session_run(input logic long_run);
      logic [TIME_W-1:0] t0, cur;
      int unsigned       n, roll;
      case ($urandom_range(0, 9))
         0:       t0 = 32'hFFFF_FFFF - $urandom_range(0, 3000);   // runs across the wrap
         1:       t0 = '0;                                       // start time of zero
         2:       t0 = 32'($urandom_range(1, 5000));
         default: t0 = $urandom;
      endcase
      // now and then the old session is reused without a fresh start
      if ($urandom_range(0, 19) != 0)
         push_word(REQ_START_NEW, t0 - 32'($urandom_range(0, 100)), 8'($urandom), $urandom);
      push_word(REQ_MARK_START, t0, 8'($urandom), $urandom);
      n = (long_run || $urandom_range(0, 6) == 0) ? $urandom_range(33, 70)
                                                   : $urandom_range(3, 20);
      cur = t0;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 76) begin
            // steps sized so that early hits fall inside the guard window
            cur = cur + 32'($urandom_range(0, gen_guard / 4 + 30));
            if ($urandom_range(0, 9) == 0)
               push_word(REQ_HIT, cur, 8'($urandom), $urandom);
            else
               push_word(REQ_HIT, cur, 8'($urandom),
                         cur - 32'($urandom_range(0, 5)));
         end else if (roll < 88) begin
            if ($urandom_range(0, 1) == 0)
               push_word(REQ_TICK, t0 + 32'($urandom_range(0, gen_par + 20)),
                         8'($urandom), $urandom);
            else
               push_word(REQ_TICK, cur, 8'($urandom), $urandom);
         end else if (roll < 91) begin
            push_drain();
         end else begin
            push_noise();
         end
      end
      roll = $urandom_range(0, 9);
      if (roll < 4)
         push_word(REQ_FORCE_STOP, cur, 8'($urandom), $urandom);
      else if (roll < 6)
         push_word(REQ_ABORT, cur, 8'($urandom), $urandom);
      if ($urandom_range(0, 4) != 0)
         push_word(REQ_CLEAR_DONE, cur, 8'($urandom), $urandom);
      if ($urandom_range(0, 9) == 0)
         push_word(REQ_CLEAR_DONE, cur, 8'($urandom), $urandom);
   endtask

   initial begin : stimulus
      int unsigned phase_no;

      // directed: limit of three, short par, short guard, slot zero in use
      program_regs(3, 50, 20, 0);
      push_word(REQ_HIT, 32'd100, 8'h00, 32'd100);            // no session yet
      push_word(REQ_MARK_START, 32'd100, 8'h00, 32'd0);       // ignored without start_new
      push_word(REQ_TICK, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      push_word(REQ_CLEAR_DONE, 32'd0, 8'h00, 32'd0);         // not showing clear
      push_word(3'd7, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);   // unknown kind
      push_word(REQ_START_NEW, 32'd0, 8'h00, 32'd0);
      push_word(REQ_HIT, 32'd5, 8'h11, 32'd5);                // armed, not running
      push_word(REQ_MARK_START, 32'd0, 8'h00, 32'd0);         // start time of zero
      push_word(REQ_HIT, 32'd10, 8'h22, 32'd10);              // inside guard window
      push_word(REQ_HIT, 32'd20, 8'hFF, 32'd25);              // first slot
      push_word(REQ_TICK, 32'd49, 8'h00, 32'd0);              // par not yet due
      push_word(REQ_TICK, 32'd50, 8'h00, 32'd0);              // par due
      push_word(REQ_HIT, 32'd60, 8'h00, 32'hFFFF_FFFF);
      push_word(REQ_HIT, 32'd70, 8'h5A, 32'd0);               // reaches the limit
      push_word(REQ_HIT, 32'd80, 8'hA5, 32'd80);              // after auto stop
      push_word(REQ_CLEAR_DONE, 32'd90, 8'h00, 32'd0);        // total with zero start
      // guard window and par deadline across the time wrap
      push_word(REQ_START_NEW, 32'hFFFF_FFE0, 8'h00, 32'd0);
      push_word(REQ_MARK_START, 32'hFFFF_FFF0, 8'h00, 32'd0);
      push_word(REQ_HIT, 32'hFFFF_FFFF, 8'h01, 32'hFFFF_FFFF); // still inside guard
      push_word(REQ_HIT, 32'd5, 8'h02, 32'd6);
      push_word(REQ_TICK, 32'd34, 8'h00, 32'd0);
      push_word(REQ_FORCE_STOP, 32'd40, 8'h00, 32'd0);
      push_word(REQ_CLEAR_DONE, 32'd41, 8'h00, 32'd0);
      push_word(REQ_MARK_START, 32'd50, 8'h00, 32'd0);        // restart from stopped
      push_word(REQ_ABORT, 32'd60, 8'h00, 32'd0);

      // random phases, extremes of the registers first
      phase_no = 0;
      while (words_queued < WORD_TARGET) begin
         case (phase_no)
            0: program_regs(32, 999999, 65535, 1);
            1: program_regs(63, 1, 0, 0);           // limit above the ring size
            2: program_regs(0, 0, 0, 1);            // unlimited ring overwrite
            3: program_regs(1, 999999, 0, 0);
            4: program_regs(32, 0, 65535, 0);
            default: begin
               program_regs($urandom_range(0, 63),
                            ($urandom_range(0, 2) == 0) ? 0 :
                            ($urandom_range(0, 1) == 0) ? $urandom_range(1, 2000)
                                                        : $urandom_range(0, 999999),
                            ($urandom_range(0, 1) == 0) ? $urandom_range(0, 200)
                                                        : $urandom_range(0, 65535),
                            $urandom_range(0, 1));
            end
         endcase
         gen_calm = (phase_no % 4 == 3);    // some phases run with no idling at all
         session_run(phase_no < 3);
         repeat ($urandom_range(1, 4)) session_run(1'b0);
         phase_no++;
      end

      // all words sent, all results back, then a short tail
      while (stim_q.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (END_CYC) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rsp.size()));
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
